// ===== rtl/gbr_pkg.sv =====
`timescale 1ns / 1ps
package gbr_pkg;

  localparam int CH_W         = 8;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 12;
  localparam int ROW_W        = 12;
  localparam int COL_OUT_W    = 10;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 4095;
  localparam int MIN_DIM       = 3;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  localparam int PIX_W = $bits(pixel_t);

endpackage

// ===== rtl/pix_in_if.sv =====
`timescale 1ns / 1ps
interface pix_in_if
  import gbr_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t in_blue;
  chan_t in_green;
  chan_t in_red;

  modport source (output valid, output in_blue, output in_green, output in_red, input ready);
  modport sink (input valid, input in_blue, input in_green, input in_red, output ready);
endinterface

// ===== rtl/blur_out_if.sv =====
`timescale 1ns / 1ps
interface blur_out_if
  import gbr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  chan_t                out_blue;
  chan_t                out_green;
  chan_t                out_red;
  logic [COL_OUT_W-1:0] out_col;
  logic [ROW_W-1:0]     out_row;
  logic                 frame_last;

  modport source (
    output valid, output out_blue, output out_green, output out_red,
    output out_col, output out_row, output frame_last, input ready
  );
  modport sink (
    input valid, input out_blue, input out_green, input out_red,
    input out_col, input out_row, input frame_last, output ready
  );
endinterface

// ===== rtl/cfg_wr_if.sv =====
`timescale 1ns / 1ps
interface cfg_wr_if
  import gbr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/gbr_ram.sv =====
`timescale 1ns / 1ps
module gbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/gaussian_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// A window's last pixel word is held in stage 1, its result word in the output register.
// Throughput: one pixel word per cycle unless the output stalls, set by the single pass
// that reads and rewrites the line memories (read at accept, old row copied at advance).
// Reset (synchronous, active low) clears the window, the position counters and the pipeline
// and loads the size registers with 640 by 480; the line memories keep their contents.
module gaussian_blur_3x3_rgb
  import gbr_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  pix_in_if.sink    in_ch,
  blur_out_if.source out_ch,
  cfg_wr_if.sink    cfg_ch
);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = (CFG_WIDTH_W > $clog2(MAX_WIDTH + 1)) ? CFG_WIDTH_W
                                                                : $clog2(MAX_WIDTH + 1);
  localparam int CXW   = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;
  localparam int HW    = ROW_W + 1;

  function automatic chan_t blur_ch(input chan_t p [3][3]);
    logic [CH_W-1:0] s;
    s = (p[0][0] >> 4) + (p[0][1] >> 3) + (p[0][2] >> 4)
      + (p[1][0] >> 3) + (p[1][1] >> 2) + (p[1][2] >> 3)
      + (p[2][0] >> 4) + (p[2][1] >> 3) + (p[2][2] >> 4);
    return s;
  endfunction

  logic [CFG_WIDTH_W-1:0]  img_width_r;
  logic [CFG_HEIGHT_W-1:0] img_height_r;
  logic [WW-1:0]           w_eff;
  logic [HW-1:0]           h_eff;

  logic [COL_W-1:0] col_count_r, col_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             wrap;
  logic             accept;
  logic             in_ready;

  logic             s1_valid_r;
  pixel_t           s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  logic             s1_adv;

  pixel_t older_rd, newer_rd, pix_in;
  pixel_t [2:0][2:0] win_r, win_nxt;
  chan_t  tap_b [3][3];
  chan_t  tap_g [3][3];
  chan_t  tap_r [3][3];
  logic [CXW-1:0] col_m2;

  logic                 out_valid_r;
  pixel_t               out_pix_r;
  logic [COL_OUT_W-1:0] out_col_r;
  logic [ROW_W-1:0]     out_row_r;
  logic                 out_last_r;

  // Configuration.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= CFG_WIDTH_W'(RESET_WIDTH);
      img_height_r <= CFG_HEIGHT_W'(RESET_HEIGHT);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IMAGE_WIDTH:  img_width_r  <= cfg_ch.data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: img_height_r <= cfg_ch.data[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (WW'(img_width_r) < WW'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (WW'(img_width_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(img_width_r);
    end
    if (HW'(img_height_r) < HW'(MIN_DIM)) begin
      h_eff = HW'(MIN_DIM);
    end else if (HW'(img_height_r) > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(img_height_r);
    end
  end

  // Position counters.
  assign wrap    = (WW'(col_count_r) >= w_eff) || (HW'(row_count_r) >= h_eff);
  assign col_cur = wrap ? '0 : col_count_r;
  assign row_cur = wrap ? '0 : row_count_r;

  always_comb begin
    if (WW'(col_cur) + WW'(1) >= w_eff) begin
      col_count_nxt = '0;
      row_count_nxt = (HW'(row_cur) + HW'(1) >= h_eff) ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_count_nxt = col_cur + COL_W'(1);
      row_count_nxt = row_cur;
    end
  end

  // Handshake.
  assign s1_adv   = s1_valid_r && (!s1_emit_r || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign pix_in = '{red: in_ch.in_red, green: in_ch.in_green, blue: in_ch.in_blue};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        col_count_r <= col_count_nxt;
        row_count_r <= row_count_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= pix_in;
      s1_col_r  <= col_cur;
      s1_row_r  <= row_cur;
      s1_emit_r <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      s1_last_r <= (WW'(col_cur) == w_eff - WW'(1)) && (HW'(row_cur) == h_eff - HW'(1));
    end
  end

  // Line memories: the newer row is read and replaced at accept, the older row
  // takes the newer row's old word when stage 1 advances.
  gbr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (accept),
    .waddr (col_cur),
    .wdata (pix_in),
    .re    (accept),
    .raddr (col_cur),
    .rdata (newer_rd)
  );

  gbr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (newer_rd),
    .re    (accept),
    .raddr (col_cur),
    .rdata (older_rd)
  );

  // Window.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = older_rd;
    win_nxt[1][2] = newer_rd;
    win_nxt[2][2] = s1_pix_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        tap_b[r][c] = win_nxt[r][c].blue;
        tap_g[r][c] = win_nxt[r][c].green;
        tap_r[r][c] = win_nxt[r][c].red;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // Output register.
  assign col_m2 = CXW'(s1_col_r) - CXW'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_pix_r.blue  <= blur_ch(tap_b);
      out_pix_r.green <= blur_ch(tap_g);
      out_pix_r.red   <= blur_ch(tap_r);
      out_col_r       <= col_m2[COL_OUT_W-1:0];
      out_row_r       <= s1_row_r - ROW_W'(2);
      out_last_r      <= s1_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_blue   = out_pix_r.blue;
  assign out_ch.out_green  = out_pix_r.green;
  assign out_ch.out_red    = out_pix_r.red;
  assign out_ch.out_col    = out_col_r;
  assign out_ch.out_row    = out_row_r;
  assign out_ch.frame_last = out_last_r;

  a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(win_r))
    else $error("window changed without a pipeline advance");

  a_line_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_adv) |-> (s1_col_r != col_cur))
    else $error("line memory read and write hit the same column");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_count_r) < WW'(MAX_WIDTH))
    else $error("column counter beyond line memory depth");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pix_r.blue <= 8'd247 && out_pix_r.green <= 8'd247
                     && out_pix_r.red <= 8'd247))
    else $error("blurred channel exceeds kernel bound");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted word lost before the window stage");
endmodule
